### src/adpcm_frame_decoder_unit_assert.svh
// Assertion macros for the ADPCM frame decoder.
`ifndef ADPCM_FRAME_DECODER_UNIT_ASSERT_SVH
`define ADPCM_FRAME_DECODER_UNIT_ASSERT_SVH

// prop must hold at every edge out of reset
`define ADPCM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expr must never be true out of reset
`define ADPCM_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### src/adpcm_pkg.sv
`timescale 1ns / 1ps

package adpcm_pkg;

	localparam int unsigned SAMPLES_PER_FRAME = 14;
	localparam int unsigned CNT_W             = 4;
	localparam int unsigned NIB_W             = 4;
	localparam int unsigned SAMPLE_W          = 16;
	localparam int unsigned NIBBLES_W         = SAMPLES_PER_FRAME * NIB_W;
	localparam int unsigned HEADER_W          = 8;
	localparam int unsigned CFG_IDX_W         = 3;
	localparam int unsigned CFG_DATA_W        = 64;
	localparam int unsigned HIST_W            = 32;
	localparam int unsigned NUM_COEF_REGS     = 4;
	localparam int unsigned ACC_W             = 34;
	localparam int unsigned FRAC_BITS         = 11;
	localparam int          ROUND_ADD         = 1024;
	localparam int          SAMPLE_MAX        = 32767;
	localparam int          SAMPLE_MIN        = -32768;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL_OLD,
		ST_MUL_NEW
	} state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_01   = 3'd0,
		REG_COEF_23   = 3'd1,
		REG_COEF_45   = 3'd2,
		REG_COEF_67   = 3'd3,
		REG_INIT_HIST = 3'd4
	} cfg_reg_t;

	// load: c2*h2 plus nibble term into accumulator; sel_new: multiply c1*h1
	typedef struct packed {
		logic load;
		logic sel_new;
	} mac_ctrl_t;

endpackage

### src/adpcm_frame_if.sv
`timescale 1ns / 1ps

interface adpcm_frame_if;
	logic        valid;
	logic        ready;
	logic [7:0]  frame_header;
	logic [55:0] frame_nibbles;
	logic        restart;

	modport source (output valid, output frame_header, output frame_nibbles,
		output restart, input ready);
	modport sink (input valid, input frame_header, input frame_nibbles,
		input restart, output ready);
endinterface

### src/adpcm_sample_if.sv
`timescale 1ns / 1ps

interface adpcm_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

### src/adpcm_frame_decoder_unit.sv
`timescale 1ns / 1ps
// ADPCM frame decoder, one channel of 4-bit DSP ADPCM.
// frame (sink): one request is an 8-byte frame: header, fourteen nibbles and
//   a restart flag that reloads the two history samples from initial_history.
// pcm (source): fourteen signed 16-bit samples per frame, first nibble first,
//   last high on the fourteenth.
// cfg: write-only port; index 0..3 hold coefficient pairs, 4 the start
//   history. Write only while the decoder is idle.
// Timing: a frame is taken only when the decoder is idle. Each sample goes
//   through the single 16x16 multiplier in ST_MUL_OLD (c2*h2) and then
//   ST_MUL_NEW (c1*h1 with rounding and saturation), so a frame keeps the
//   decoder busy until its fourteenth sample is emitted, and the next frame
//   is taken only once the decoder is back in idle. Each sample is
//   registered in the output register after ST_MUL_OLD and ST_MUL_NEW.
// The last sample waits in the output register while the next frame is
//   accepted. When pcm stalls on an earlier sample, decoding halts until
//   the pending sample is taken.
// Reset clears coefficients, start history, decoder history and the output valid flag.

module adpcm_frame_decoder_unit import adpcm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	adpcm_frame_if.sink           frame,
	adpcm_sample_if.source        pcm
);

	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SAMPLES_PER_FRAME - 1);

	state_t                     state_q;
	state_t                     state_d;
	mac_ctrl_t                  mac_ctrl;
	logic [CFG_DATA_W-1:0]      coef_q [NUM_COEF_REGS];
	logic [HIST_W-1:0]          init_hist_q;
	logic [CFG_DATA_W-1:0]      coef_reg;
	logic [2*SAMPLE_W-1:0]      pair;
	logic [CNT_W-1:0]           cnt_q;
	logic [NIBBLES_W-1:0]       nibbles_q;
	logic [3:0]                 shift_q;
	logic signed [SAMPLE_W-1:0] c1_q;
	logic signed [SAMPLE_W-1:0] c2_q;
	logic signed [SAMPLE_W-1:0] h1_q;
	logic signed [SAMPLE_W-1:0] h2_q;
	logic signed [SAMPLE_W-1:0] mac_sample;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_last_q;
	logic                       accept;
	logic                       emit;

	assign frame.ready = (state_q == ST_IDLE);
	assign accept      = frame.valid && frame.ready;
	assign emit        = (state_q == ST_MUL_NEW) && (!out_valid_q || pcm.ready);

	assign pcm.valid  = out_valid_q;
	assign pcm.sample = out_sample_q;
	assign pcm.last   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF_REGS; i++) begin
				coef_q[i] <= '0;
			end
			init_hist_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				REG_COEF_01, REG_COEF_23, REG_COEF_45, REG_COEF_67: begin
					coef_q[cfg_index[1:0]] <= cfg_wdata;
				end
				REG_INIT_HIST: begin
					init_hist_q <= cfg_wdata[HIST_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign coef_reg = coef_q[frame.frame_header[6:5]];
	assign pair     = frame.frame_header[4] ? coef_reg[63:32] : coef_reg[31:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			c1_q    <= pair[SAMPLE_W-1:0];
			c2_q    <= pair[2*SAMPLE_W-1:SAMPLE_W];
			shift_q <= frame.frame_header[3:0];
		end
		if (accept) begin
			nibbles_q <= frame.frame_nibbles;
		end else if (emit) begin
			nibbles_q <= nibbles_q << NIB_W;
		end
		if (emit) begin
			out_sample_q <= mac_sample;
			out_last_q   <= (cnt_q == LAST_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			h1_q        <= '0;
			h2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
				if (frame.restart) begin
					h1_q <= init_hist_q[SAMPLE_W-1:0];
					h2_q <= init_hist_q[HIST_W-1:SAMPLE_W];
				end
			end else if (emit) begin
				cnt_q <= cnt_q + 1'b1;
				h1_q  <= mac_sample;
				h2_q  <= h1_q;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pcm.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d          = state_q;
		mac_ctrl.load    = 1'b0;
		mac_ctrl.sel_new = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_MUL_OLD;
				end
			end
			ST_MUL_OLD: begin
				mac_ctrl.load = 1'b1;
				state_d       = ST_MUL_NEW;
			end
			ST_MUL_NEW: begin
				mac_ctrl.sel_new = 1'b1;
				if (emit) begin
					state_d = (cnt_q == LAST_IDX) ? ST_IDLE : ST_MUL_OLD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	adpcm_mac u_mac (
		.clk    (clk),
		.ctrl   (mac_ctrl),
		.nibble (nibbles_q[NIBBLES_W-1 -: NIB_W]),
		.shift  (shift_q),
		.c1     (c1_q),
		.c2     (c2_q),
		.h1     (h1_q),
		.h2     (h2_q),
		.sample (mac_sample)
	);

endmodule

### src/adpcm_mac.sv
`timescale 1ns / 1ps

module adpcm_mac import adpcm_pkg::*; (
	input  logic                       clk,
	input  mac_ctrl_t                  ctrl,
	input  logic [NIB_W-1:0]           nibble,
	input  logic [3:0]                 shift,
	input  logic signed [SAMPLE_W-1:0] c1,
	input  logic signed [SAMPLE_W-1:0] c2,
	input  logic signed [SAMPLE_W-1:0] h1,
	input  logic signed [SAMPLE_W-1:0] h2,
	output logic signed [SAMPLE_W-1:0] sample
);

	logic signed [SAMPLE_W-1:0]   mul_a;
	logic signed [SAMPLE_W-1:0]   mul_b;
	logic signed [2*SAMPLE_W-1:0] prod;
	logic signed [ACC_W-1:0]      prod_ext;
	logic signed [ACC_W-1:0]      nib_ext;
	logic signed [ACC_W-1:0]      base;
	logic signed [ACC_W-1:0]      sum;
	logic signed [ACC_W-1:0]      quo;
	logic signed [ACC_W-1:0]      acc_q;

	assign mul_a    = ctrl.sel_new ? c1 : c2;
	assign mul_b    = ctrl.sel_new ? h1 : h2;
	assign prod     = mul_a * mul_b;
	assign prod_ext = {{(ACC_W-2*SAMPLE_W){prod[2*SAMPLE_W-1]}}, prod};
	assign nib_ext  = {{(ACC_W-NIB_W){nibble[NIB_W-1]}}, nibble};
	assign base     = ((nib_ext <<< shift) <<< FRAC_BITS) + ACC_W'(ROUND_ADD);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= base + prod_ext;
		end
	end

	assign sum = acc_q + prod_ext;
	assign quo = sum >>> FRAC_BITS;

	always_comb begin
		if (quo > ACC_W'(SAMPLE_MAX)) begin
			sample = SAMPLE_W'(SAMPLE_MAX);
		end else if (quo < ACC_W'(SAMPLE_MIN)) begin
			sample = SAMPLE_W'(SAMPLE_MIN);
		end else begin
			sample = quo[SAMPLE_W-1:0];
		end
	end

endmodule

### src/adpcm_checker.sv
`timescale 1ns / 1ps
`include "adpcm_frame_decoder_unit_assert.svh"

module adpcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_sample,
	input logic        out_last
);

	// a frame occupies the decoder until its last sample is produced
	`ADPCM_ASSERT(a_busy_after_accept, clk, arst_n, (in_valid && in_ready) |=> !in_ready, "ready after frame request")

	// only a frame's last sample may still be pending when a new frame enters
	`ADPCM_ASSERT_NEVER(a_accept_mid_frame, clk, arst_n, in_valid && in_ready && out_valid && !out_last, "frame accepted mid frame")

	`ADPCM_ASSERT_NEVER(a_ready_mid_frame, clk, arst_n, out_valid && !out_last && in_ready, "idle with mid-frame sample pending")

	`ADPCM_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_sample) && $stable(out_last)), "stalled sample changed")

endmodule

bind adpcm_frame_decoder_unit adpcm_checker u_adpcm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (frame.valid),
	.in_ready   (frame.ready),
	.out_valid  (pcm.valid),
	.out_ready  (pcm.ready),
	.out_sample (pcm.sample),
	.out_last   (pcm.last)
);
